/* rtl/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, codes and defaults for the dual stack shared store.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WIDTH_DEFAULT = 32;

  localparam logic [2:0] CMD_PUSH_A = 3'd0;
  localparam logic [2:0] CMD_PUSH_B = 3'd1;
  localparam logic [2:0] CMD_POP_A  = 3'd2;
  localparam logic [2:0] CMD_POP_B  = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic exec;
    logic done;
  } ctrl_t;

endpackage

/* rtl/dual_stack_shared_store.sv */
// ----------------------------------------------------------------------------
// dual_stack_shared_store
// Two LIFO stacks in one shared store, A growing up and B growing down.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. It goes through the
// cycle it is taken in (counters update, a push writes the store), the read
// state, which reads both tops from the two-port store, and the done state,
// in which done is high and the result stands on the outputs. The result is
// shown for that single cycle only and is not held, so the receiver must take
// it then. busy is high from the cycle after acceptance through the done
// cycle; the next command may be taken the cycle after done.
module dual_stack_shared_store
  import dss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 command,
  input  logic signed [31:0]         data_value,
  output logic                       done,
  output logic [1:0]                 status,
  output logic signed [31:0]         top_a,
  output logic signed [31:0]         top_b,
  output logic [$clog2(DEPTH+1)-1:0] count_a,
  output logic [$clog2(DEPTH+1)-1:0] count_b,
  output logic                       empty_a,
  output logic                       empty_b
);

  ctrl_t ctrl;

  dss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  dss_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .command    (command),
    .data_value (data_value),
    .status     (status),
    .top_a      (top_a),
    .top_b      (top_b),
    .count_a    (count_a),
    .count_b    (count_b),
    .empty_a    (empty_a),
    .empty_b    (empty_b)
  );

  assign done = ctrl.done;

endmodule

/* rtl/dss_ram.sv */
// ----------------------------------------------------------------------------
// dss_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/dss_ctrl.sv */
// ----------------------------------------------------------------------------
// dss_ctrl
// Command sequencer: accept, read both tops, present the result.
// ----------------------------------------------------------------------------
module dss_ctrl
  import dss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy      = (state != ST_IDLE);
  assign ctrl.exec = (state == ST_IDLE) && start;
  assign ctrl.done = (state == ST_DONE);

endmodule

/* rtl/dss_datapath.sv */
// ----------------------------------------------------------------------------
// dss_datapath
// Fill counters, status register and the shared store.
// ----------------------------------------------------------------------------
module dss_datapath
  import dss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_t                      ctrl,
  input  logic [2:0]                 command,
  input  logic signed [31:0]         data_value,
  output logic [1:0]                 status,
  output logic signed [31:0]         top_a,
  output logic signed [31:0]         top_b,
  output logic [$clog2(DEPTH+1)-1:0] count_a,
  output logic [$clog2(DEPTH+1)-1:0] count_b,
  output logic                       empty_a,
  output logic                       empty_b
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [CW-1:0]    fill_a;
  logic [CW-1:0]    fill_b;
  logic [CW-1:0]    fill_a_next;
  logic [CW-1:0]    fill_b_next;
  logic [1:0]       stat_reg;
  logic [1:0]       stat_next;
  logic             full;
  logic             we;
  logic [CW-1:0]    waddr_w;
  logic [CW-1:0]    raddr_a_w;
  logic [CW-1:0]    raddr_b_w;
  logic [WIDTH-1:0] rdata_a;
  logic [WIDTH-1:0] rdata_b;
  logic signed [WIDTH-1:0] rd_a_s;
  logic signed [WIDTH-1:0] rd_b_s;

  assign full = ({1'b0, fill_a} + {1'b0, fill_b}) >= {1'b0, DEPTH_C};

  always_comb begin
    fill_a_next = fill_a;
    fill_b_next = fill_b;
    stat_next   = STAT_OK;
    we          = 1'b0;
    waddr_w     = fill_a;
    case (command)
      CMD_PUSH_A: begin
        if (full) begin
          stat_next = STAT_OVERFLOW;
        end else begin
          we          = 1'b1;
          fill_a_next = fill_a + ONE_C;
        end
      end
      CMD_PUSH_B: begin
        waddr_w = DEPTH_C - ONE_C - fill_b;
        if (full) begin
          stat_next = STAT_OVERFLOW;
        end else begin
          we          = 1'b1;
          fill_b_next = fill_b + ONE_C;
        end
      end
      CMD_POP_A: begin
        if (fill_a == '0) begin
          stat_next = STAT_UNDERFLOW;
        end else begin
          fill_a_next = fill_a - ONE_C;
        end
      end
      CMD_POP_B: begin
        if (fill_b == '0) begin
          stat_next = STAT_UNDERFLOW;
        end else begin
          fill_b_next = fill_b - ONE_C;
        end
      end
      CMD_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_a <= '0;
      fill_b <= '0;
    end else if (ctrl.exec) begin
      fill_a <= fill_a_next;
      fill_b <= fill_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      stat_reg <= stat_next;
    end
  end

  assign raddr_a_w = fill_a - ONE_C;
  assign raddr_b_w = DEPTH_C - fill_b;

  dss_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ctrl.exec && we),
    .waddr   (waddr_w[AW-1:0]),
    .wdata   (WIDTH'($unsigned(data_value))),
    .raddr_a (raddr_a_w[AW-1:0]),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b_w[AW-1:0]),
    .rdata_b (rdata_b)
  );

  assign rd_a_s  = $signed(rdata_a);
  assign rd_b_s  = $signed(rdata_b);
  assign empty_a = (fill_a == '0);
  assign empty_b = (fill_b == '0);
  assign count_a = fill_a;
  assign count_b = fill_b;
  assign status  = ctrl.done ? stat_reg : STAT_OK;
  assign top_a   = (ctrl.done && !empty_a) ? 32'(rd_a_s) : '0;
  assign top_b   = (ctrl.done && !empty_b) ? 32'(rd_b_s) : '0;

endmodule

/* bench/tb_dual_stack_shared_store.sv */
// ----------------------------------------------------------------------------
// tb_dual_stack_shared_store
// Self-checking bench for the two stacks that share one store.
// ----------------------------------------------------------------------------
// A clocked driver sends push, pop and query commands from a pending queue.
// At each accepted command, a shadow copy of both stacks computes the result
// that the block should report. A clocked monitor takes every done strobe and
// compares all fields with the oldest predicted result. The bench starts with
// a directed sweep: empty pops, unused codes, extreme values, filling the
// store until the stacks meet, and refused pushes. Random segments follow.
// Some segments lean toward filling the store and some toward draining it,
// so that overflow and underflow are both reached often. Sender gaps vary
// from phase to phase.
// ----------------------------------------------------------------------------
module tb_dual_stack_shared_store;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [2:0] CMD_LAST = 3'd7;
  localparam int RANDOM_ITEMS = 1450;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] data;
    int          idle_pct;
    bit          drain;
  } stack_cmd_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [31:0]   top_a;
    logic [31:0]   top_b;
    logic [CW-1:0] count_a;
    logic [CW-1:0] count_b;
    logic          empty_a;
    logic          empty_b;
  } stack_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] command = CMD_QUERY;
  logic signed [31:0] data_value = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic signed [31:0] top_a;
  logic signed [31:0] top_b;
  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic empty_a;
  logic empty_b;

  stack_cmd_t  pending_items[$];
  stack_view_t expected_views[$];
  logic [31:0] shadow_store[DEPTH];
  int          fill_a = 0;
  int          fill_b = 0;
  int          items_sent = 0;
  int          total_items = 0;
  int          mismatches = 0;
  bit          slot_free;
  stack_cmd_t  next_item;
  stack_view_t got_view;
  stack_view_t want_view;

  dual_stack_shared_store #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH_DEFAULT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .data_value(data_value),
    .done(done),
    .status(status),
    .top_a(top_a),
    .top_b(top_b),
    .count_a(count_a),
    .count_b(count_b),
    .empty_a(empty_a),
    .empty_b(empty_b)
  );

  always #5 clk = ~clk;

  task automatic apply_stack_command(input logic [2:0] cmd, input logic [31:0] data);
    stack_view_t v;
    bit full;
    full = (fill_a + fill_b) >= DEPTH;
    v.status = STAT_OK;
    case (cmd)
      CMD_PUSH_A: begin
        if (full) begin
          v.status = STAT_OVERFLOW;
        end else begin
          shadow_store[fill_a] = data;
          fill_a++;
        end
      end
      CMD_PUSH_B: begin
        if (full) begin
          v.status = STAT_OVERFLOW;
        end else begin
          shadow_store[DEPTH - 1 - fill_b] = data;
          fill_b++;
        end
      end
      CMD_POP_A: begin
        if (fill_a == 0) v.status = STAT_UNDERFLOW;
        else fill_a--;
      end
      CMD_POP_B: begin
        if (fill_b == 0) v.status = STAT_UNDERFLOW;
        else fill_b--;
      end
      default: begin
      end
    endcase
    v.top_a = (fill_a != 0) ? shadow_store[fill_a - 1] : '0;
    v.top_b = (fill_b != 0) ? shadow_store[DEPTH - fill_b] : '0;
    v.count_a = CW'(fill_a);
    v.count_b = CW'(fill_b);
    v.empty_a = (fill_a == 0);
    v.empty_b = (fill_b == 0);
    expected_views.push_back(v);
  endtask

  function automatic void queue_command(input logic [2:0] cmd, input logic [31:0] data,
                                        input int idle_pct, input bit drain);
    stack_cmd_t c;
    c.cmd = cmd;
    c.data = data;
    c.idle_pct = idle_pct;
    c.drain = drain;
    pending_items.push_back(c);
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      command <= CMD_QUERY;
      data_value <= '0;
    end else begin
      slot_free = !start;
      if (start && !busy) begin
        apply_stack_command(command, data_value);
        items_sent++;
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (pending_items.size() != 0 &&
            $urandom_range(0, 99) >= pending_items[0].idle_pct &&
            !(pending_items[0].drain && expected_views.size() != 0)) begin
          next_item = pending_items.pop_front();
          start <= 1'b1;
          command <= next_item.cmd;
          data_value <= next_item.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      got_view = {status, top_a, top_b, count_a, count_b, empty_a, empty_b};
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item: status=%0d top_a=%h top_b=%h count_a=%0d count_b=%0d",
                   got_view.status, got_view.top_a, got_view.top_b,
                   got_view.count_a, got_view.count_b);
        end
      end else begin
        want_view = expected_views.pop_front();
        if (got_view !== want_view) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected status=%0d top_a=%h top_b=%h cnt=%0d/%0d empty=%b%b",
                     $realtime, want_view.status, want_view.top_a, want_view.top_b,
                     want_view.count_a, want_view.count_b, want_view.empty_a,
                     want_view.empty_b);
            $display("                 actual   status=%0d top_a=%h top_b=%h cnt=%0d/%0d empty=%b%b",
                     got_view.status, got_view.top_a, got_view.top_b,
                     got_view.count_a, got_view.count_b, got_view.empty_a,
                     got_view.empty_b);
          end
        end
      end
    end
  end

  initial begin
    int idle_phases[4];
    int phase;
    int seg_len;
    int mode;
    int r;
    int seg_idle;
    bit seg_drain;
    logic [2:0] cmd;

    idle_phases = '{0, 61, 0, 28};

    // empty stacks, unused codes
    queue_command(CMD_QUERY, random_word(), 0, 1'b0);
    queue_command(CMD_POP_A, random_word(), 0, 1'b0);
    queue_command(CMD_POP_B, random_word(), 0, 1'b0);
    for (int c = CMD_QUERY + 1; c <= CMD_LAST; c++) begin
      queue_command(3'(c), 32'hFFFF_FFFF, 0, 1'b0);
    end
    // extremes, then fill until the stacks meet
    queue_command(CMD_PUSH_A, 32'h8000_0000, 0, 1'b0);
    queue_command(CMD_PUSH_B, 32'h7FFF_FFFF, 0, 1'b0);
    for (int k = 0; k < DEPTH - 2; k++) begin
      queue_command((k % 2 == 0) ? CMD_PUSH_A : CMD_PUSH_B, random_word(), 0, 1'b0);
    end
    queue_command(CMD_PUSH_A, 32'h1234_5678, 0, 1'b0);
    queue_command(CMD_PUSH_B, 32'h8765_4321, 0, 1'b0);
    queue_command(CMD_POP_A, random_word(), 0, 1'b1);
    queue_command(CMD_POP_B, random_word(), 0, 1'b0);

    phase = 0;
    while (pending_items.size() < RANDOM_ITEMS) begin
      seg_len = $urandom_range(10, 60);
      r = $urandom_range(0, 99);
      mode = (r < 40) ? 0 : (r < 80) ? 1 : (r < 95) ? 2 : 3;
      seg_idle = idle_phases[phase % 4];
      phase++;
      seg_drain = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: cmd = (r < 70) ? 3'($urandom_range(CMD_PUSH_A, CMD_PUSH_B)) :
                   (r < 90) ? 3'($urandom_range(CMD_POP_A, CMD_POP_B)) :
                              3'($urandom_range(CMD_QUERY, CMD_LAST));
          1: cmd = (r < 70) ? 3'($urandom_range(CMD_POP_A, CMD_POP_B)) :
                   (r < 90) ? 3'($urandom_range(CMD_PUSH_A, CMD_PUSH_B)) :
                              3'($urandom_range(CMD_QUERY, CMD_LAST));
          2: cmd = 3'($urandom_range(CMD_PUSH_A, CMD_LAST));
          default: cmd = (r < 50) ? 3'($urandom_range(CMD_QUERY, CMD_LAST)) :
                                    3'($urandom_range(CMD_POP_A, CMD_POP_B));
        endcase
        queue_command(cmd, random_word(), seg_idle, seg_drain && k == 0);
      end
    end
    total_items = pending_items.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (items_sent == total_items);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/dss_pkg.sv
rtl/dss_ram.sv
rtl/dss_ctrl.sv
rtl/dss_datapath.sv
rtl/dual_stack_shared_store.sv
bench/tb_dual_stack_shared_store.sv
